[rtl/llqm_pkg.sv]
// ----------------------------------------------------------------------------
// llqm_pkg
// Types and codes shared by the linked list queue manager.
// ----------------------------------------------------------------------------
package llqm_pkg;

    localparam int NODE_W = 8;
    localparam int CNT_W  = 9;
    localparam int LINK_W = 9;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [LINK_W-1:0] t_link;

    // next-table entry that marks the end of the list
    localparam t_link END_MARK = 9'h100;

    typedef enum logic [2:0] {
        OP_ADD_FRONT    = 3'd0,
        OP_ADD_BACK     = 3'd1,
        OP_TAKE_FRONT   = 3'd2,
        OP_TAKE_BACK    = 3'd3,
        OP_REMOVE       = 3'd4,
        OP_INSERT_AFTER = 3'd5
    } t_op;

endpackage

[rtl/linked_list_queue_manager.sv]
// ----------------------------------------------------------------------------
// linked_list_queue_manager
// One singly linked list over a pool of node indices, next pointers in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries an opcode, a node and an
//   anchor node. Output channel (o_out_valid / i_out_stall) returns one result
//   per transfer: the taken node, an error flag, the count and the front and
//   back nodes after the operation.
//   One operation is in flight at a time. The result register is loaded:
//     in the cycle after the transfer: add front, add to empty list,
//       rejected add or insert, empty-list errors, take of a single node,
//       take back of two nodes;
//     after the head-link wait or second link write: add back, take front,
//       insert after a lone node;
//     after a walk, one node per cycle: take back, remove, insert after.
//   The walk rate is set by the single, registered read port of the
//   next-pointer RAM; each read address comes straight from the previous
//   read data.
//   A new transfer is taken in the idle state while the result register is
//   empty or being drained, so a stalled receiver holds the result and
//   blocks the input only until it takes it.
//   Reset empties the list (count, head, tail to zero); the RAM is not
//   cleared, entries are written before they are read.
// ----------------------------------------------------------------------------
module linked_list_queue_manager
    import llqm_pkg::*;
#(
    parameter int NODES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_node_id,
    input  logic [7:0] i_anchor_id,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_taken_node,
    output logic       o_taken_valid,
    output logic       o_not_found,
    output logic [8:0] o_entry_count,
    output logic [7:0] o_front_node,
    output logic [7:0] o_back_node,
    output logic       o_list_empty
);

    localparam int     DEPTH = (NODES < 256) ? NODES : 256;
    localparam int     AW    = $clog2(DEPTH);
    localparam t_count CAP   = t_count'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_HEAD,     // wait for next of head
        S_CUT_TAIL,     // walk to the node before the tail
        S_SEEK_PRED,    // walk to the predecessor of the removed node
        S_SEEK_ANCHOR,  // walk looking for the anchor
        S_UNLINK,       // wait for next of removed node
        S_SPLICE,       // wait for next of anchor
        S_WRITE2        // second link write
    } t_state;

    t_state r_state, n_state;
    t_node  r_head, n_head;
    t_node  r_tail, n_tail;
    t_count r_count, n_count;
    t_node  r_node, n_node;
    t_node  r_anchor, n_anchor;
    t_node  r_ptr, n_ptr;
    t_count r_left, n_left;
    t_link  r_wdat, n_wdat;
    t_node  r_taken, n_taken;
    logic   r_tvalid, n_tvalid;

    logic   r_out_valid;
    t_node  r_out_taken;
    logic   r_out_tvalid;
    logic   r_out_nf;
    t_count r_out_count;
    t_node  r_out_front;
    t_node  r_out_back;

    logic   fin, fin_nf;
    logic   mem_we, mem_re;
    t_node  mem_waddr, mem_raddr;
    t_link  mem_wdata, mem_rdata;
    t_node  lk;
    logic   in_xfer, can_add;

    // next-pointer memory
    llqm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr[AW-1:0]),
        .i_wr_data (mem_wdata),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr[AW-1:0]),
        .o_rd_data (mem_rdata)
    );

    // handshake
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign can_add    = ({1'b0, i_node_id} < CAP) && (r_count < CAP);
    assign lk         = mem_rdata[NODE_W-1:0];

    // sequencer: read, modify, write back the list
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_node   = r_node;
        n_anchor = r_anchor;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_wdat   = r_wdat;
        n_taken  = r_taken;
        n_tvalid = r_tvalid;
        fin      = 1'b0;
        fin_nf   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_node   = i_node_id;
                    n_anchor = i_anchor_id;
                    n_taken  = '0;
                    n_tvalid = 1'b0;
                    case (t_op'(i_opcode))
                        OP_ADD_FRONT, OP_ADD_BACK: begin
                            fin = 1'b1;
                            if (!can_add) begin
                                fin_nf = 1'b1;
                            end else if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = i_node_id;
                                mem_wdata = END_MARK;
                                n_head    = i_node_id;
                                n_tail    = i_node_id;
                                n_count   = t_count'(1);
                            end else if (t_op'(i_opcode) == OP_ADD_FRONT) begin
                                mem_we    = 1'b1;
                                mem_waddr = i_node_id;
                                mem_wdata = {1'b0, r_head};
                                n_head    = i_node_id;
                                n_count   = r_count + t_count'(1);
                            end else begin
                                // link old tail now, terminate new node next
                                fin       = 1'b0;
                                mem_we    = 1'b1;
                                mem_waddr = r_tail;
                                mem_wdata = {1'b0, i_node_id};
                                n_tail    = i_node_id;
                                n_count   = r_count + t_count'(1);
                                n_ptr     = i_node_id;
                                n_wdat    = END_MARK;
                                n_state   = S_WRITE2;
                            end
                        end
                        OP_TAKE_FRONT, OP_TAKE_BACK, OP_REMOVE: begin
                            if (r_count == '0) begin
                                fin    = 1'b1;
                                fin_nf = 1'b1;
                            end else if ((t_op'(i_opcode) == OP_TAKE_FRONT) ||
                                         ((t_op'(i_opcode) == OP_REMOVE) &&
                                          (i_node_id == r_head))) begin
                                if (t_op'(i_opcode) == OP_TAKE_FRONT) begin
                                    n_taken  = r_head;
                                    n_tvalid = 1'b1;
                                end
                                if (r_count == t_count'(1)) begin
                                    fin     = 1'b1;
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_count = '0;
                                end else begin
                                    mem_re    = 1'b1;
                                    mem_raddr = r_head;
                                    n_state   = S_POP_HEAD;
                                end
                            end else if ((t_op'(i_opcode) == OP_TAKE_BACK) ||
                                         (i_node_id == r_tail)) begin
                                if (t_op'(i_opcode) == OP_TAKE_BACK) begin
                                    n_taken  = r_tail;
                                    n_tvalid = 1'b1;
                                end
                                if (r_count == t_count'(1)) begin
                                    fin     = 1'b1;
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_count = '0;
                                end else if (r_count == t_count'(2)) begin
                                    // head is the new tail
                                    fin       = 1'b1;
                                    mem_we    = 1'b1;
                                    mem_waddr = r_head;
                                    mem_wdata = END_MARK;
                                    n_tail    = r_head;
                                    n_count   = r_count - t_count'(1);
                                end else begin
                                    mem_re    = 1'b1;
                                    mem_raddr = r_head;
                                    n_left    = r_count - t_count'(2);
                                    n_state   = S_CUT_TAIL;
                                end
                            end else if (r_count == t_count'(1)) begin
                                fin    = 1'b1;
                                fin_nf = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_ptr     = r_head;
                                n_left    = r_count - t_count'(1);
                                n_state   = S_SEEK_PRED;
                            end
                        end
                        OP_INSERT_AFTER: begin
                            if (!can_add || (r_count == '0)) begin
                                fin    = 1'b1;
                                fin_nf = 1'b1;
                            end else if (r_head == i_anchor_id) begin
                                if (i_anchor_id == r_tail) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = i_anchor_id;
                                    mem_wdata = {1'b0, i_node_id};
                                    n_tail    = i_node_id;
                                    n_count   = r_count + t_count'(1);
                                    n_ptr     = i_node_id;
                                    n_wdat    = END_MARK;
                                    n_state   = S_WRITE2;
                                end else begin
                                    mem_re    = 1'b1;
                                    mem_raddr = i_anchor_id;
                                    n_state   = S_SPLICE;
                                end
                            end else if (r_count == t_count'(1)) begin
                                fin    = 1'b1;
                                fin_nf = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_left    = r_count - t_count'(1);
                                n_state   = S_SEEK_ANCHOR;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_POP_HEAD: begin
                fin     = 1'b1;
                n_head  = lk;
                n_count = r_count - t_count'(1);
                n_state = S_IDLE;
            end

            S_CUT_TAIL: begin
                if (r_left == t_count'(1)) begin
                    fin       = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = lk;
                    mem_wdata = END_MARK;
                    n_tail    = lk;
                    n_count   = r_count - t_count'(1);
                    n_state   = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = lk;
                    n_left    = r_left - t_count'(1);
                end
            end

            S_SEEK_PRED: begin
                if (lk == r_node) begin
                    // r_ptr is the predecessor, fetch the removed node's link
                    mem_re    = 1'b1;
                    mem_raddr = r_node;
                    n_state   = S_UNLINK;
                end else if (r_left == t_count'(1)) begin
                    fin     = 1'b1;
                    fin_nf  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = lk;
                    n_ptr     = lk;
                    n_left    = r_left - t_count'(1);
                end
            end

            S_SEEK_ANCHOR: begin
                if (lk == r_anchor) begin
                    if (r_anchor == r_tail) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_anchor;
                        mem_wdata = {1'b0, r_node};
                        n_tail    = r_node;
                        n_count   = r_count + t_count'(1);
                        n_ptr     = r_node;
                        n_wdat    = END_MARK;
                        n_state   = S_WRITE2;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_anchor;
                        n_state   = S_SPLICE;
                    end
                end else if (r_left == t_count'(1)) begin
                    fin     = 1'b1;
                    fin_nf  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = lk;
                    n_left    = r_left - t_count'(1);
                end
            end

            S_UNLINK: begin
                fin       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = mem_rdata;
                n_count   = r_count - t_count'(1);
                n_state   = S_IDLE;
            end

            S_SPLICE: begin
                // new node takes the anchor's successor, anchor points to it
                mem_we    = 1'b1;
                mem_waddr = r_node;
                mem_wdata = {1'b0, lk};
                n_count   = r_count + t_count'(1);
                n_ptr     = r_anchor;
                n_wdat    = {1'b0, r_node};
                n_state   = S_WRITE2;
            end

            S_WRITE2: begin
                fin       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = r_wdat;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, working registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_node   <= n_node;
            r_anchor <= n_anchor;
            r_ptr    <= n_ptr;
            r_left   <= n_left;
            r_wdat   <= n_wdat;
            r_taken  <= n_taken;
            r_tvalid <= n_tvalid;
            if (fin) begin
                r_out_valid  <= 1'b1;
                r_out_taken  <= n_taken;
                r_out_tvalid <= n_tvalid;
                r_out_nf     <= fin_nf;
                r_out_count  <= n_count;
                r_out_front  <= n_head;
                r_out_back   <= n_tail;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_taken_node  = r_out_taken;
    assign o_taken_valid = r_out_tvalid;
    assign o_not_found   = r_out_nf;
    assign o_entry_count = r_out_count;
    assign o_front_node  = r_out_front;
    assign o_back_node   = r_out_back;
    assign o_list_empty  = (r_out_count == '0);

    // count never passes the pool capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("list count above capacity");

    // an empty list has cleared pointers
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_head == '0) && (r_tail == '0)))
        else $error("empty list with stale head or tail");

    // while an operation is in flight the result register is free
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending during operation");

    // no read and write of the link RAM in the same cycle
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("link RAM read and write overlap");

endmodule

[rtl/llqm_ram.sv]
// ----------------------------------------------------------------------------
// llqm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module llqm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
